### rtl/core/affine_tilemap_background_pixel_core_defines.svh
// ----------------------------------------------------------------------------
// Affine background core - assertion macros
// Shared property wrappers, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TILEMAP_BACKGROUND_PIXEL_CORE_DEFINES_SVH
`define AFFINE_TILEMAP_BACKGROUND_PIXEL_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ATBP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ATBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/atbp_pkg.sv
// ----------------------------------------------------------------------------
// Affine background core - package
// Widths, codes and shared types of the affine tilemap background.
// ----------------------------------------------------------------------------
`default_nettype none

package atbp_pkg;

  localparam int unsigned VideoWords = 16384;
  localparam int unsigned MapAw      = 14;  // map row*128 + map column
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 26;
  localparam int unsigned InDataW    = 48;
  localparam int unsigned OutDataW   = 16;
  localparam int unsigned PosW       = 10;  // signed screen coordinate after flips
  localparam int unsigned SumW       = 28;  // texture sum, never overflows this width

  typedef enum logic [1:0] {
    ModePixel = 2'd0,
    ModeWrite = 2'd1,
    ModeLine  = 2'd2
  } atbp_mode_e;

  typedef enum logic [2:0] {
    RegMatrixA    = 3'd0,
    RegMatrixB    = 3'd1,
    RegMatrixC    = 3'd2,
    RegMatrixD    = 3'd3,
    RegCenter     = 3'd4,
    RegScroll     = 3'd5,
    RegControl    = 3'd6,
    RegMosaicSize = 3'd7
  } atbp_reg_e;

  // Control register bit positions
  localparam int unsigned CtlHflip     = 0;
  localparam int unsigned CtlVflip     = 1;
  localparam int unsigned CtlRepLo     = 2;
  localparam int unsigned CtlMosaic    = 4;
  localparam int unsigned CtlBg1Mosaic = 5;
  localparam int unsigned CtlSecond    = 6;
  localparam int unsigned CtlAbove     = 7;
  localparam int unsigned CtlBelow     = 8;
  localparam int unsigned CtlPrio0Lo   = 9;
  localparam int unsigned CtlPrio1Lo   = 13;
  localparam int unsigned CtlW         = 17;

  localparam logic [1:0] RepeatClear    = 2'd2;
  localparam logic [1:0] RepeatTileZero = 2'd3;

  typedef struct packed {
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [15:0] d;
    logic [25:0]        center;
    logic [25:0]        scroll;
  } atbp_xform_t;

  typedef struct packed {
    atbp_mode_e  mode;
    logic [13:0] waddr;
    logic [15:0] wdata;
  } atbp_side_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [3:0] prio;
    logic [7:0] palette;
    logic       main;
    logic       sub;
  } atbp_res_t;

endpackage

`default_nettype wire

### rtl/core/atbp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports with enables; read data is registered and
// a read of the address being written returns the old word.
// ----------------------------------------------------------------------------
`default_nettype none

module atbp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [Aw-1:0]    raddr_a_i,
  output logic [Width-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [Aw-1:0]    raddr_b_i,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_a_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
    end
    if (re_b_i) begin
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

### rtl/core/atbp_coord.sv
// ----------------------------------------------------------------------------
// Affine background core - texture coordinate pipeline
// Two stages: the matrix products, then the sums that give the map address,
// the pixel select within the tile and the out-of-range flag.
// ----------------------------------------------------------------------------
`default_nettype none

module atbp_coord import atbp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  atbp_xform_t            xform_i,
  input  logic signed [PosW-1:0] x_i,
  input  logic signed [PosW-1:0] y_i,
  output logic [MapAw-1:0]       tile_addr_o,
  output logic [5:0]             pixel_sel_o,
  output logic                   oob_o
);

  logic signed [15:0] ma, mb, mc, md;
  logic signed [12:0] hc, vc, hs, vs;
  logic signed [13:0] dx, dy;
  logic signed [10:0] cx, cy;
  logic signed [SumW-1:0] p_acx, p_bcy, p_ccx, p_dcy, p_by, p_dy, p_ax, p_cx;
  logic [SumW-1:0] acx_q, bcy_q, ccx_q, dcy_q, by_q, dy_q, ax_q, cx_q;
  logic [SumW-1:0] hc_sh, vc_sh, sum_x, sum_y;
  logic [MapAw-1:0] tile_addr_q;
  logic [5:0]       pixel_sel_q;
  logic             oob_q;

  assign ma = xform_i.a;
  assign mb = xform_i.b;
  assign mc = xform_i.c;
  assign md = xform_i.d;
  assign hc = xform_i.center[12:0];
  assign vc = xform_i.center[25:13];
  assign hs = xform_i.scroll[12:0];
  assign vs = xform_i.scroll[25:13];

  // Clip scroll minus centre to 10 bits, keeping the sign from bit 13
  assign dx = {hs[12], hs} - {hc[12], hc};
  assign dy = {vs[12], vs} - {vc[12], vc};
  assign cx = {dx[13], dx[9:0]};
  assign cy = {dy[13], dy[9:0]};

  assign p_acx = ma * cx;
  assign p_bcy = mb * cy;
  assign p_ccx = mc * cx;
  assign p_dcy = md * cy;
  assign p_by  = mb * y_i;
  assign p_dy  = md * y_i;
  assign p_ax  = ma * x_i;
  assign p_cx  = mc * x_i;

  // Origin terms drop their six low fraction bits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acx_q <= {p_acx[SumW-1:6], 6'b0};
      bcy_q <= {p_bcy[SumW-1:6], 6'b0};
      ccx_q <= {p_ccx[SumW-1:6], 6'b0};
      dcy_q <= {p_dcy[SumW-1:6], 6'b0};
      by_q  <= {p_by[SumW-1:6], 6'b0};
      dy_q  <= {p_dy[SumW-1:6], 6'b0};
      ax_q  <= p_ax;
      cx_q  <= p_cx;
    end
  end

  assign hc_sh = {{(SumW-21){hc[12]}}, hc, 8'b0};
  assign vc_sh = {{(SumW-21){vc[12]}}, vc, 8'b0};
  assign sum_x = acx_q + bcy_q + by_q + hc_sh + ax_q;
  assign sum_y = ccx_q + dcy_q + dy_q + vc_sh + cx_q;

  // Integer part starts at bit 8; anything above bit 17 lies off the map
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tile_addr_q <= {sum_y[17:11], sum_x[17:11]};
      pixel_sel_q <= {sum_y[10:8], sum_x[10:8]};
      oob_q       <= |{sum_x[SumW-1:18], sum_y[SumW-1:18]};
    end
  end

  assign tile_addr_o = tile_addr_q;
  assign pixel_sel_o = pixel_sel_q;
  assign oob_o       = oob_q;

endmodule

`default_nettype wire

### rtl/core/affine_tilemap_background_pixel_core.sv
// ----------------------------------------------------------------------------
// Affine tilemap background pixel core
// Per-pixel affine lookup into a 128x128 tile map held in video memory.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle while input ready is high: a pixel to render,
// a video memory word write or a start of line, and returns one result item for
// each, in order. Each item passes the screen position and mosaic register, the
// matrix products, then the sums, then the tile byte and the pixel byte from the
// two read ports of the video memory, which depend on each other, before it
// reaches the output register. Writes go through the same memory at the stage
// of the tile read, so every item sees exactly the writes before it. Video
// memory is not cleared after reset and must be written before it is shown.
// A two-entry output stage keeps input ready registered; input stalls only when
// both entries hold results that have not been taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "affine_tilemap_background_pixel_core_defines.svh"

module affine_tilemap_background_pixel_core import atbp_pkg::*; #(
  parameter int unsigned VIDEO_WORDS = VideoWords
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // line[8:0], mosaic_line_offset[12:9], write_address[26:13], write_data[42:27]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // priority_res[3:0], palette_index[11:4], to_main_screen[12], to_sub_screen[13]
  output logic [OutDataW-1:0] m_axis_tdata,
  // pixel_valid[0]
  output logic                m_axis_tuser
);

  localparam int unsigned VramAw = $clog2(VIDEO_WORDS);

  // Configuration
  atbp_xform_t xform_q, xform_d;
  logic [CtlW-1:0] ctl_q, ctl_d;
  logic [4:0]      msize_q, msize_d;
  logic [1:0]      rep;

  // Mosaic counters
  logic [8:0] pos_q, pos_d;
  logic [4:0] cnt_q, cnt_d, cnt_dec;

  // Input decode
  logic            adv, in_acc;
  atbp_mode_e      in_mode;
  logic [8:0]      in_line;
  logic [3:0]      in_off;
  atbp_side_t      in_side;
  logic [PosW-1:0] xs, ys, x_scr, y_scr;

  // Pipeline
  logic            s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;
  atbp_side_t      s1_side_q, s2_side_q, s3_side_q;
  logic [PosW-1:0] s1_x_q, s1_y_q;
  atbp_mode_e      s4_mode_q, s5_mode_q;
  logic [5:0]      s4_sel_q;
  logic            s4_oob_q, s5_oob_q;

  logic [MapAw-1:0] tile_addr;
  logic [5:0]       pixel_sel;
  logic             oob;
  logic             ram_we;
  logic [15:0]      rd_a, rd_b;
  logic [7:0]       tile, color_raw;

  // Result and output stage
  atbp_res_t res, out_q, out_d, skid_q, skid_d;
  logic      out_valid_q, out_valid_d, skid_valid_q, skid_valid_d, push;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    xform_d = xform_q;
    ctl_d   = ctl_q;
    msize_d = msize_q;
    if (cfg_valid_i) begin
      unique case (atbp_reg_e'(cfg_index_i))
        RegMatrixA:    xform_d.a = cfg_data_i[15:0];
        RegMatrixB:    xform_d.b = cfg_data_i[15:0];
        RegMatrixC:    xform_d.c = cfg_data_i[15:0];
        RegMatrixD:    xform_d.d = cfg_data_i[15:0];
        RegCenter:     xform_d.center = cfg_data_i;
        RegScroll:     xform_d.scroll = cfg_data_i;
        RegControl:    ctl_d = cfg_data_i[CtlW-1:0];
        RegMosaicSize: msize_d = cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign rep = ctl_q[CtlRepLo+1:CtlRepLo];

  assign adv           = !skid_valid_q;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  assign in_mode       = atbp_mode_e'(s_axis_tuser);
  assign in_line       = s_axis_tdata[8:0];
  assign in_off        = s_axis_tdata[12:9];
  assign in_side.mode  = in_mode;
  assign in_side.waddr = s_axis_tdata[26:13];
  assign in_side.wdata = s_axis_tdata[42:27];

  // Screen position of this item: mosaic position and line, then flips
  assign xs    = {1'b0, pos_q};
  assign ys    = {1'b0, in_line} - (ctl_q[CtlBg1Mosaic] ? {6'b0, in_off} : 10'd0);
  assign x_scr = ctl_q[CtlHflip] ? 10'd255 - xs : xs;
  assign y_scr = ctl_q[CtlVflip] ? 10'd255 - ys : ys;

  assign cnt_dec = cnt_q - 5'd1;

  always_comb begin
    pos_d = pos_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      case (in_mode)
        ModeLine: begin
          pos_d = 9'd0;
          cnt_d = msize_q;
        end
        ModePixel: begin
          if (!ctl_q[CtlMosaic]) begin
            pos_d = pos_q + 9'd1;
          end else begin
            cnt_d = cnt_dec;
            if (cnt_dec == 5'd0) begin
              cnt_d = msize_q;
              pos_d = pos_q + {4'b0, msize_q};
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xform_q    <= '0;
      ctl_q      <= '0;
      msize_q    <= 5'd1;
      pos_q      <= '0;
      cnt_q      <= 5'd1;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      xform_q <= xform_d;
      ctl_q   <= ctl_d;
      msize_q <= msize_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      if (adv) begin
        s1_valid_q <= s_axis_tvalid;
        s2_valid_q <= s1_valid_q;
        s3_valid_q <= s2_valid_q;
        s4_valid_q <= s3_valid_q;
        s5_valid_q <= s4_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q <= in_side;
      s1_x_q    <= x_scr;
      s1_y_q    <= y_scr;
      s2_side_q <= s1_side_q;
      s3_side_q <= s2_side_q;
      s4_mode_q <= s3_side_q.mode;
      s4_sel_q  <= pixel_sel;
      s4_oob_q  <= oob;
      s5_mode_q <= s4_mode_q;
      s5_oob_q  <= s4_oob_q;
    end
  end

  atbp_coord u_coord (
    .clk_i       (clk_i),
    .en_i        (adv),
    .xform_i     (xform_q),
    .x_i         (s1_x_q),
    .y_i         (s1_y_q),
    .tile_addr_o (tile_addr),
    .pixel_sel_o (pixel_sel),
    .oob_o       (oob)
  );

  // Write at the tile-read stage: later items read after it, earlier ones before
  assign ram_we = adv && s3_valid_q && (s3_side_q.mode == ModeWrite);
  assign tile   = (rep == RepeatTileZero && s4_oob_q) ? 8'd0 : rd_a[7:0];

  atbp_ram #(
    .Width (16),
    .Depth (VIDEO_WORDS)
  ) u_vram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (VramAw'(s3_side_q.waddr)),
    .wdata_i   (s3_side_q.wdata),
    .re_a_i    (adv),
    .raddr_a_i (VramAw'(tile_addr)),
    .rdata_a_o (rd_a),
    .re_b_i    (adv),
    .raddr_b_i (VramAw'({tile, s4_sel_q})),
    .rdata_b_o (rd_b)
  );

  assign color_raw = (rep == RepeatClear && s5_oob_q) ? 8'd0 : rd_b[15:8];

  always_comb begin
    atbp_res_t pix;
    pix.pixel_valid = 1'b1;
    pix.main        = ctl_q[CtlAbove];
    pix.sub         = ctl_q[CtlBelow];
    if (ctl_q[CtlSecond]) begin
      pix.prio    = color_raw[7] ? ctl_q[CtlPrio1Lo+3:CtlPrio1Lo]
                                 : ctl_q[CtlPrio0Lo+3:CtlPrio0Lo];
      pix.palette = {1'b0, color_raw[6:0]};
    end else begin
      pix.prio    = ctl_q[CtlPrio0Lo+3:CtlPrio0Lo];
      pix.palette = color_raw;
    end
    res = '0;
    if (s5_mode_q == ModePixel && pix.palette != 8'd0) begin
      res = pix;
    end
  end

  // Output register with one skid entry behind it
  assign push = adv && s5_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_d       = res;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.pixel_valid;
  assign m_axis_tdata  = {2'b0, out_q.sub, out_q.main, out_q.palette, out_q.prio};

  `ATBP_ASSERT_SAME(a_skid_only_on_stall, $rose(skid_valid_q), $past(out_valid_q && !m_axis_tready), "skid entry filled while the output was free")
  `ATBP_ASSERT_NEXT(a_mosaic_reload, in_acc && in_mode == ModePixel && ctl_q[CtlMosaic] && cnt_q == 5'd1, cnt_q == $past(msize_q), "mosaic countdown did not reload")
  `ATBP_ASSERT_SAME(a_opaque_pixel, out_valid_q && out_q.pixel_valid, out_q.palette != 8'd0, "visible pixel with a zero palette index")

endmodule

`default_nettype wire
